FILE: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the run-length decoder checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed: a implies b");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed: a implies b in the next cycle");

`endif

FILE: hdl/brle_pkg.sv
// ---------------------------------------------------------------------------
// brle_pkg
// Types and constants shared by the bitmap run-length decoder and its checker.
// ---------------------------------------------------------------------------
package brle_pkg;

	// Default image geometry.
	localparam int DEF_IMAGE_WIDTH      = 256;
	localparam int DEF_IMAGE_HEIGHT     = 192;
	localparam int DEF_PIXELS_PER_COUNT = 4;

	// Paint values.
	localparam logic [7:0] VALUE_START = 8'd128;
	localparam logic [7:0] VALUE_ON    = 8'd255;
	localparam logic [7:0] VALUE_OFF   = 8'd0;

	// Output field widths.
	localparam int BLOCK_W = 14;

	// Result queue depth, a power of two of at least four.
	localparam int QUEUE_DEPTH = 4;

	// One emitted span.
	typedef struct packed {
		logic [7:0]         value;
		logic [BLOCK_W-1:0] first;
		logic [BLOCK_W-1:0] count;
		logic               complete;
	} span_t;

endpackage

FILE: hdl/blob_bitmap_rle_decoder_core.sv
// ---------------------------------------------------------------------------
// blob_bitmap_rle_decoder_core
// Decodes alternating run-length counts of a two-level bitmap into spans.
// ---------------------------------------------------------------------------
//  channel  handshake             payload
//  input    in_valid / in_ready   data_byte, last_byte
//  output   out_valid / out_ready pixel_value, first_block, block_count,
//                                 image_complete
//
// One byte is taken per cycle while in_ready is high; its spans are written
// into a small result queue at the same edge and appear on the output from its head.
// A byte may produce two spans (run, then fill); the queue absorbs them.
// in_ready is high while the queue has room for two spans, so a stalled
// output blocks the input once fewer than two queue entries are free.
// arst_n clears the decode state and empties the queue.
module blob_bitmap_rle_decoder_core #(
	parameter int IMAGE_WIDTH      = brle_pkg::DEF_IMAGE_WIDTH,
	parameter int IMAGE_HEIGHT     = brle_pkg::DEF_IMAGE_HEIGHT,
	parameter int PIXELS_PER_COUNT = brle_pkg::DEF_PIXELS_PER_COUNT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [7:0]                   data_byte,
	input  logic                         last_byte,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [7:0]                   pixel_value,
	output logic [brle_pkg::BLOCK_W-1:0] first_block,
	output logic [brle_pkg::BLOCK_W-1:0] block_count,
	output logic                         image_complete
);
	import brle_pkg::*;

	localparam int BLOCKS_PER_ROW = (IMAGE_WIDTH + PIXELS_PER_COUNT - 1) / PIXELS_PER_COUNT;
	localparam int TOTAL_BLOCKS   = BLOCKS_PER_ROW * IMAGE_HEIGHT;
	localparam int NB_W           = $clog2(TOTAL_BLOCKS + 1);
	localparam int CW             = (NB_W > 16) ? NB_W : 16;
	localparam logic [CW-1:0] TOTAL_C = CW'(TOTAL_BLOCKS);
	localparam int PTR_W          = $clog2(QUEUE_DEPTH);
	localparam int CNT_W          = $clog2(QUEUE_DEPTH + 1);

	// Decode state.
	logic [7:0]      pending_high_q;
	logic            have_pending_q;
	logic            inside_run_q;
	logic [7:0]      current_value_q;
	logic [NB_W-1:0] next_block_q;

	// Result queue.
	span_t            queue_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;

	logic            in_fire;
	logic            out_fire;
	logic [CW-1:0]   nbx;
	logic            not_full;
	logic            run_now;
	logic [CW-1:0]   run_req;
	logic [CW-1:0]   remain0;
	logic [CW-1:0]   run_cnt;
	logic [CW-1:0]   run_end;
	logic [7:0]      run_val;
	logic [CW-1:0]   nb_mid;
	logic [7:0]      val_mid;
	logic            fill_now;
	logic [CW-1:0]   fill_cnt;
	span_t           run_span;
	span_t           fill_span;
	span_t           push0;
	logic [1:0]      n_push;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;
	assign in_ready = (fill_q <= CNT_W'(QUEUE_DEPTH - 2));

	// Run span from a completed count, clipped to the blocks that remain.
	always_comb begin
		nbx      = CW'(next_block_q);
		not_full = (nbx < TOTAL_C);
		run_now  = not_full && have_pending_q;
		run_req  = CW'({pending_high_q, data_byte});
		if (run_req == '0) begin
			run_req = CW'(1);
		end
		remain0  = TOTAL_C - nbx;
		run_cnt  = (run_req > remain0) ? remain0 : run_req;
		run_end  = nbx + run_cnt;
		run_val  = inside_run_q ? VALUE_OFF : VALUE_ON;

		run_span.value    = run_val;
		run_span.first    = nbx[BLOCK_W-1:0];
		run_span.count    = run_cnt[BLOCK_W-1:0];
		run_span.complete = (run_end >= TOTAL_C);
	end

	// Fill span for the blocks left after the last byte.
	always_comb begin
		nb_mid   = run_now ? run_end : nbx;
		val_mid  = run_now ? run_val : current_value_q;
		fill_now = last_byte && (nb_mid < TOTAL_C);
		fill_cnt = TOTAL_C - nb_mid;

		fill_span.value    = val_mid;
		fill_span.first    = nb_mid[BLOCK_W-1:0];
		fill_span.count    = fill_cnt[BLOCK_W-1:0];
		fill_span.complete = 1'b1;

		push0  = run_now ? run_span : fill_span;
		n_push = 2'(run_now) + 2'(fill_now);
	end

	// Decode state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_high_q  <= '0;
			have_pending_q  <= 1'b0;
			inside_run_q    <= 1'b0;
			current_value_q <= VALUE_START;
			next_block_q    <= '0;
		end else if (in_fire) begin
			if (last_byte) begin
				pending_high_q  <= '0;
				have_pending_q  <= 1'b0;
				inside_run_q    <= 1'b0;
				current_value_q <= VALUE_START;
				next_block_q    <= '0;
			end else if (run_now) begin
				have_pending_q  <= 1'b0;
				inside_run_q    <= !inside_run_q;
				current_value_q <= run_val;
				next_block_q    <= run_end[NB_W-1:0];
			end else if (not_full) begin
				pending_high_q <= data_byte;
				have_pending_q <= 1'b1;
			end
		end
	end

	// Queue storage: up to two spans written per request.
	always_ff @(posedge clk) begin
		if (in_fire && (n_push != 2'd0)) begin
			queue_q[wr_ptr_q] <= push0;
		end
		if (in_fire && (n_push == 2'd2)) begin
			queue_q[wr_ptr_q + PTR_W'(1)] <= fill_span;
		end
	end

	// Queue pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (in_fire) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			end
			if (out_fire) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			fill_q <= fill_q + CNT_W'(in_fire ? n_push : 2'd0) - CNT_W'(out_fire);
		end
	end

	// Output from the queue head.
	assign out_valid      = (fill_q != '0);
	assign pixel_value    = queue_q[rd_ptr_q].value;
	assign first_block    = queue_q[rd_ptr_q].first;
	assign block_count    = queue_q[rd_ptr_q].count;
	assign image_complete = queue_q[rd_ptr_q].complete;

endmodule

FILE: hdl/brle_checker.sv
// ---------------------------------------------------------------------------
// brle_checker
// Port-level assertions for the bitmap run-length decoder, bound to the core.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module brle_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [7:0]                   pixel_value,
	input logic [brle_pkg::BLOCK_W-1:0] first_block,
	input logic [brle_pkg::BLOCK_W-1:0] block_count,
	input logic                         image_complete
);
	import brle_pkg::*;

	// A stalled span stays on the output.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	// A stalled span keeps its value, first block and count.
	`ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(pixel_value) && $stable(first_block) && $stable(block_count))

	// Only the three paint values ever appear.
	`ASSERT_IMPLY(a_value_set, clk, arst_n, out_valid, pixel_value == VALUE_ON || pixel_value == VALUE_OFF || pixel_value == VALUE_START)

	// A gray span is always a fill, so it always ends the image.
	`ASSERT_IMPLY(a_gray_fill, clk, arst_n, out_valid && (pixel_value == VALUE_START), image_complete)

endmodule

bind blob_bitmap_rle_decoder_core brle_checker u_brle_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.pixel_value    (pixel_value),
	.first_block    (first_block),
	.block_count    (block_count),
	.image_complete (image_complete)
);
